>>> design/rgbf_pkg.sv
// Package with the level and phase types and constants for the rainbow fade PWM.
`timescale 1ns / 1ps

package rgbf_pkg;

    localparam int unsigned LEVEL_WIDTH = 8;
    localparam int unsigned PHASE_WIDTH = 3;

    typedef logic [LEVEL_WIDTH-1:0] level_t;
    typedef logic [PHASE_WIDTH-1:0] phase_t;

    // Brightness of the three channels.
    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
    } color_t;

    localparam level_t LEVEL_MAX  = level_t'(255);
    localparam level_t LEVEL_ZERO = level_t'(0);
    localparam level_t STEP_RESET = level_t'(1);

    // Fade phases and the channel that each one moves.
    localparam phase_t PHASE_RED_YELLOW   = phase_t'(0); // green up
    localparam phase_t PHASE_YELLOW_GREEN = phase_t'(1); // red down
    localparam phase_t PHASE_GREEN_CYAN   = phase_t'(2); // blue up
    localparam phase_t PHASE_CYAN_BLUE    = phase_t'(3); // green down
    localparam phase_t PHASE_BLUE_VIOLET  = phase_t'(4); // red up
    localparam phase_t PHASE_VIOLET_RED   = phase_t'(5); // blue down

    localparam color_t COLOR_RESET = '{red: LEVEL_MAX, green: LEVEL_ZERO, blue: LEVEL_ZERO};

endpackage

>>> design/rgbf_fade.sv
// One step of the six-phase rainbow fade with saturating raise and lower.
`timescale 1ns / 1ps

module rgbf_fade
(
    input  rgbf_pkg::color_t color,
    input  rgbf_pkg::phase_t phase,
    input  rgbf_pkg::level_t step,
    output rgbf_pkg::color_t color_next,
    output rgbf_pkg::phase_t phase_next
);

    import rgbf_pkg::*;

    logic [LEVEL_WIDTH:0] raise_sum;
    level_t               raise_in;
    level_t               raise_out;
    level_t               lower_in;
    level_t               lower_out;
    logic                 done;

    // The raising channel of the current phase.
    always_comb
    begin
        case (phase)
            PHASE_RED_YELLOW:  raise_in = color.green;
            PHASE_GREEN_CYAN:  raise_in = color.blue;
            default:           raise_in = color.red;
        endcase
    end

    // The lowering channel of the current phase.
    always_comb
    begin
        case (phase)
            PHASE_YELLOW_GREEN: lower_in = color.red;
            PHASE_CYAN_BLUE:    lower_in = color.green;
            default:            lower_in = color.blue;
        endcase
    end

    assign raise_sum = {1'b0, raise_in} + {1'b0, step};

    always_comb
    begin
        if (raise_sum > {1'b0, LEVEL_MAX})
        begin
            raise_out = LEVEL_MAX;
        end
        else
        begin
            raise_out = raise_sum[LEVEL_WIDTH-1:0];
        end
    end

    assign lower_out = (lower_in < step) ? LEVEL_ZERO : level_t'(lower_in - step);

    always_comb
    begin
        color_next = color;
        done       = 1'b0;
        case (phase)
            PHASE_RED_YELLOW:
            begin
                color_next.green = raise_out;
                done             = (raise_out == LEVEL_MAX);
            end
            PHASE_YELLOW_GREEN:
            begin
                color_next.red = lower_out;
                done           = (lower_out == LEVEL_ZERO);
            end
            PHASE_GREEN_CYAN:
            begin
                color_next.blue = raise_out;
                done            = (raise_out == LEVEL_MAX);
            end
            PHASE_CYAN_BLUE:
            begin
                color_next.green = lower_out;
                done             = (lower_out == LEVEL_ZERO);
            end
            PHASE_BLUE_VIOLET:
            begin
                color_next.red = raise_out;
                done           = (raise_out == LEVEL_MAX);
            end
            PHASE_VIOLET_RED:
            begin
                color_next.blue = lower_out;
                done            = (lower_out == LEVEL_ZERO);
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (phase)
            PHASE_VIOLET_RED:
            begin
                phase_next = done ? PHASE_RED_YELLOW : phase;
            end
            PHASE_RED_YELLOW, PHASE_YELLOW_GREEN, PHASE_GREEN_CYAN,
            PHASE_CYAN_BLUE, PHASE_BLUE_VIOLET:
            begin
                phase_next = done ? phase_t'(phase + phase_t'(1)) : phase;
            end
            default:
            begin
                // Unused codes fall back to the first phase.
                phase_next = PHASE_RED_YELLOW;
            end
        endcase
    end

endmodule

>>> design/rgb_rainbow_fade_pwm.sv
// Top level of the RGB rainbow fade with 8-bit PWM outputs.
// The result of an accepted item is registered in the output register.
// Throughput: one item per cycle; the output register is refilled in the same
// cycle in which its result is taken, so only a stalled output holds the input.
// Reset: rst_n clears the tick counter, sets full red at the first phase and
// a fade step of 1; the output register is empty after reset.
`timescale 1ns / 1ps

module rgb_rainbow_fade_pwm
(
    input  logic             clk,
    input  logic             rst_n,
    // Fade step register write port.
    input  logic             cfg_write_en,
    input  rgbf_pkg::level_t cfg_write_data,
    // Tick items.
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             restart,
    // Result items.
    output logic             out_valid,
    input  logic             out_ready,
    output logic             red_on,
    output logic             green_on,
    output logic             blue_on,
    output rgbf_pkg::level_t red_level,
    output rgbf_pkg::level_t green_level,
    output rgbf_pkg::level_t blue_level,
    output rgbf_pkg::phase_t fade_phase
);

    import rgbf_pkg::*;

    // Fade configuration and PWM state.
    level_t step_reg;
    level_t tick_reg;
    level_t tick_next;
    color_t color_reg;
    color_t color_next;
    phase_t phase_reg;
    phase_t phase_next;

    // Output of the fade step unit.
    color_t fade_color;
    phase_t fade_phase_out;

    // Result register.
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   [2:0] on_reg;
    logic   [2:0] on_next;
    color_t out_color_reg;
    phase_t out_phase_reg;

    logic   accept;

    // The input is taken whenever the result register is empty or being emptied.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // The fade advances once per PWM period, on the tick where the counter is 0.
    rgbf_fade u_fade
    (
        .color      (color_reg),
        .phase      (phase_reg),
        .step       (step_reg),
        .color_next (fade_color),
        .phase_next (fade_phase_out)
    );

    // Next state and the result of one tick. The LED compare uses the levels
    // from before this tick's fade step. A restart item skips the compare and
    // returns the colors, phase and counter to their reset values.
    always_comb
    begin
        if (restart)
        begin
            on_next    = 3'b000;
            color_next = COLOR_RESET;
            phase_next = PHASE_RED_YELLOW;
            tick_next  = LEVEL_ZERO;
        end
        else
        begin
            on_next[2] = (tick_reg <= color_reg.red);
            on_next[1] = (tick_reg <= color_reg.green);
            on_next[0] = (tick_reg <= color_reg.blue);
            if (tick_reg == LEVEL_ZERO)
            begin
                color_next = fade_color;
                phase_next = fade_phase_out;
            end
            else
            begin
                color_next = color_reg;
                phase_next = phase_reg;
            end
            // The counter wraps from 255 to 0.
            tick_next = level_t'(tick_reg + level_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_write_en)
        begin
            step_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= LEVEL_ZERO;
            color_reg <= COLOR_RESET;
            phase_reg <= PHASE_RED_YELLOW;
        end
        else if (accept)
        begin
            tick_reg  <= tick_next;
            color_reg <= color_next;
            phase_reg <= phase_next;
        end
    end

    // A result stays valid until taken; a new one may load in the same cycle.
    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            on_reg        <= on_next;
            out_color_reg <= color_next;
            out_phase_reg <= phase_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_on      = on_reg[2];
    assign green_on    = on_reg[1];
    assign blue_on     = on_reg[0];
    assign red_level   = out_color_reg.red;
    assign green_level = out_color_reg.green;
    assign blue_level  = out_color_reg.blue;
    assign fade_phase  = out_phase_reg;

endmodule

>>> bench/rgb_rainbow_fade_pwm_test.sv
// Self-checking testbench for the RGB rainbow fade PWM block.
`timescale 1ns / 1ps

module rgb_rainbow_fade_pwm_test;

    import rgbf_pkg::*;

    // One result item: the three LED drives plus the levels and phase after the tick.
    typedef struct packed {
        logic   red_on;
        logic   green_on;
        logic   blue_on;
        level_t red;
        level_t green;
        level_t blue;
        phase_t phase;
    } led_frame_t;

    // One row of the directed table. A row can load a new fade step first,
    // and it can carry a typed-in frame where the answer is obvious.
    typedef struct packed {
        logic       load_step;
        level_t     step;
        logic       restart;
        logic       typed;
        led_frame_t want;
    } tick_row_t;

    // Receiver stall patterns.
    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_RARELY, RX_TOGGLE} rx_mode_t;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DIRECTED_ROWS   = 17;

    // Small mid-range step that does not divide 255, so the green ramp
    // saturates on its third fade step.
    localparam level_t STEP_UNEVEN = level_t'(100);

    localparam led_frame_t FRAME_RESTART =
        '{1'b0, 1'b0, 1'b0, LEVEL_MAX, LEVEL_ZERO, LEVEL_ZERO, PHASE_RED_YELLOW};
    localparam led_frame_t FRAME_NONE = '0;

    logic   clk;
    logic   rst_n;
    logic   cfg_write_en;
    level_t cfg_write_data;
    logic   in_valid;
    logic   in_ready;
    logic   restart;
    logic   out_valid;
    logic   out_ready;
    logic   red_on;
    logic   green_on;
    logic   blue_on;
    level_t red_level;
    level_t green_level;
    level_t blue_level;
    phase_t fade_phase;

    rgb_rainbow_fade_pwm dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .red_on         (red_on),
        .green_on       (green_on),
        .blue_on        (blue_on),
        .red_level      (red_level),
        .green_level    (green_level),
        .blue_level     (blue_level),
        .fade_phase     (fade_phase)
    );

    // Our own copy of the block's state, advanced once per accepted tick.
    level_t fade_amt;
    level_t tick_cnt;
    level_t red_lvl;
    level_t green_lvl;
    level_t blue_lvl;
    phase_t cur_phase;

    // Frames that the block still owes us, oldest first.
    led_frame_t pending_frames[$];

    int  error_count = 0;
    int  burst_left  = 0;
    bit  sender_idles = 1'b1;
    bit  hold_off_req = 1'b0;

    // The directed table. Typed-in rows cover reset, both restart flavors and
    // the first fade step at the smallest, zero, uneven and largest steps.
    tick_row_t directed_rows [DIRECTED_ROWS] = '{
        // First tick after reset: counter 0, every LED on, green moves up by 1.
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, LEVEL_MAX, level_t'(1), LEVEL_ZERO, PHASE_RED_YELLOW}},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b0, FRAME_NONE},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b0, FRAME_NONE},
        // Restart, twice in a row.
        '{1'b0, LEVEL_ZERO, 1'b1, 1'b1, FRAME_RESTART},
        '{1'b0, LEVEL_ZERO, 1'b1, 1'b1, FRAME_RESTART},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, LEVEL_MAX, level_t'(1), LEVEL_ZERO, PHASE_RED_YELLOW}},
        // Largest step: green goes straight to full and the phase advances.
        '{1'b1, LEVEL_MAX, 1'b1, 1'b1, FRAME_RESTART},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, LEVEL_MAX, LEVEL_MAX, LEVEL_ZERO, PHASE_YELLOW_GREEN}},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b0, FRAME_NONE},
        '{1'b0, LEVEL_ZERO, 1'b1, 1'b1, FRAME_RESTART},
        // Zero step: green stays at zero and the phase holds.
        '{1'b1, LEVEL_ZERO, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, LEVEL_MAX, LEVEL_ZERO, LEVEL_ZERO, PHASE_RED_YELLOW}},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b0, FRAME_NONE},
        // A step that does not divide 255.
        '{1'b1, STEP_UNEVEN, 1'b1, 1'b1, FRAME_RESTART},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, LEVEL_MAX, STEP_UNEVEN, LEVEL_ZERO, PHASE_RED_YELLOW}},
        '{1'b0, LEVEL_ZERO, 1'b0, 1'b0, FRAME_NONE},
        '{1'b0, LEVEL_ZERO, 1'b1, 1'b1, FRAME_RESTART},
        // Back to the smallest step.
        '{1'b1, STEP_RESET, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, LEVEL_MAX, level_t'(1), LEVEL_ZERO, PHASE_RED_YELLOW}}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Saturating raise and lower of one channel by the fade step.
    function automatic level_t raised(level_t v);
        logic [LEVEL_WIDTH:0] sum;
        sum = {1'b0, v} + {1'b0, fade_amt};
        return (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[LEVEL_WIDTH-1:0];
    endfunction

    function automatic level_t lowered(level_t v);
        return (v < fade_amt) ? LEVEL_ZERO : level_t'(v - fade_amt);
    endfunction

    function automatic void restore_colors();
        tick_cnt  = LEVEL_ZERO;
        red_lvl   = LEVEL_MAX;
        green_lvl = LEVEL_ZERO;
        blue_lvl  = LEVEL_ZERO;
        cur_phase = PHASE_RED_YELLOW;
    endfunction

    // Advances our state by one tick and returns the frame the block should
    // produce for it. The LED drives use the levels from before the fade step.
    function automatic led_frame_t next_pwm_frame(logic rs);
        led_frame_t f;
        logic       at_end;
        f = '0;
        if (rs)
        begin
            restore_colors();
        end
        else
        begin
            f.red_on   = (tick_cnt <= red_lvl);
            f.green_on = (tick_cnt <= green_lvl);
            f.blue_on  = (tick_cnt <= blue_lvl);
            if (tick_cnt == LEVEL_ZERO)
            begin
                at_end = 1'b0;
                case (cur_phase)
                    PHASE_RED_YELLOW:
                    begin
                        green_lvl = raised(green_lvl);
                        at_end    = (green_lvl == LEVEL_MAX);
                    end
                    PHASE_YELLOW_GREEN:
                    begin
                        red_lvl = lowered(red_lvl);
                        at_end  = (red_lvl == LEVEL_ZERO);
                    end
                    PHASE_GREEN_CYAN:
                    begin
                        blue_lvl = raised(blue_lvl);
                        at_end   = (blue_lvl == LEVEL_MAX);
                    end
                    PHASE_CYAN_BLUE:
                    begin
                        green_lvl = lowered(green_lvl);
                        at_end    = (green_lvl == LEVEL_ZERO);
                    end
                    PHASE_BLUE_VIOLET:
                    begin
                        red_lvl = raised(red_lvl);
                        at_end  = (red_lvl == LEVEL_MAX);
                    end
                    PHASE_VIOLET_RED:
                    begin
                        blue_lvl = lowered(blue_lvl);
                        at_end   = (blue_lvl == LEVEL_ZERO);
                    end
                    // An out-of-range phase only falls back to the first one.
                    default: cur_phase = PHASE_RED_YELLOW;
                endcase
                if (at_end)
                begin
                    cur_phase = (cur_phase == PHASE_VIOLET_RED) ? PHASE_RED_YELLOW
                                                                : phase_t'(cur_phase + 1);
                end
            end
            tick_cnt = level_t'(tick_cnt + 1);
        end
        f.red   = red_lvl;
        f.green = green_lvl;
        f.blue  = blue_lvl;
        f.phase = cur_phase;
        return f;
    endfunction

    // Offers one tick item and waits for it to be taken. The sender runs in
    // bursts; a gap drops valid on one falling edge and raises it on a later one.
    task automatic offer_tick(logic rs, logic typed, led_frame_t want);
        led_frame_t predicted;
        int         gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (sender_idles)
            begin
                gap = ($urandom_range(3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        restart  = rs;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        // Keep our state in step even where the frame is typed in.
        predicted = next_pwm_frame(rs);
        pending_frames.push_back(typed ? want : predicted);
    endtask

    // Stops offering and waits until every owed frame has come back.
    task automatic drain_frames();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_frames.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The fade step is only written while the block has nothing in flight.
    task automatic load_fade_step(level_t v);
        drain_frames();
        @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = v;
        @(negedge clk);
        cfg_write_en = 1'b0;
        fade_amt     = v;
    endtask

    // Random ticks at one fade step. restart_odds of zero means a clean run
    // with no restarts, which is what lets the fade walk through all phases.
    task automatic run_ticks(level_t step, int count, int restart_odds, int hold_at);
        logic rs;
        load_fade_step(step);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
            begin
                hold_off_req = 1'b1;
            end
            rs = (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0);
            offer_tick(rs, 1'b0, FRAME_NONE);
        end
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Every accepted result item is checked against the oldest owed frame.
    always @(posedge clk)
    begin
        led_frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                error_count++;
                $display("%0t: result item with no frame expected, got %0d %0d %0d %0d %0d %0d %0d",
                         $time, red_on, green_on, blue_on, red_level, green_level,
                         blue_level, fade_phase);
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("red_on", want.red_on, red_on);
                check_field("green_on", want.green_on, green_on);
                check_field("blue_on", want.blue_on, blue_on);
                check_field("red_level", want.red, red_level);
                check_field("green_level", want.green, green_level);
                check_field("blue_level", want.blue, blue_level);
                check_field("fade_phase", want.phase, fade_phase);
            end
        end
    end

    // The receiver changes its stall pattern every so often. On request it
    // holds off for a long stretch so the output register fills and the input
    // side backs up while the sender keeps offering.
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        out_ready = 1'b0;
        mode      = RX_ALWAYS;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                RX_ALWAYS: out_ready = 1'b1;
                RX_MOSTLY: out_ready = ($urandom_range(3) != 0);
                RX_RARELY: out_ready = ($urandom_range(3) == 0);
                default:   out_ready = ~out_ready;
            endcase
        end
    end

    // The run ends if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        int quiet_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = LEVEL_ZERO;
        in_valid       = 1'b0;
        restart        = 1'b0;
        fade_amt       = STEP_RESET;
        restore_colors();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table first, starting from the reset fade step of 1.
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].load_step)
            begin
                load_fade_step(directed_rows[i].step);
            end
            offer_tick(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].want);
        end

        // A clean run at the largest step: six of its seven fade steps take the
        // colors once around the whole rainbow and into the first phase again. The
        // long receiver hold-off happens early in this run.
        drain_frames();
        offer_tick(1'b1, 1'b0, FRAME_NONE);
        run_ticks(LEVEL_MAX, 1560, 0, 200);

        // Uneven step from a fresh start: green saturates on its third step.
        // The sender does not idle here.
        sender_idles = 1'b0;
        drain_frames();
        offer_tick(1'b1, 1'b0, FRAME_NONE);
        run_ticks(STEP_UNEVEN, 530, 0, -1);
        sender_idles = 1'b1;

        // Zero step, then random steps and the smallest step, with restarts
        // thrown in at random.
        run_ticks(LEVEL_ZERO, 150, 32, -1);
        run_ticks(level_t'($urandom_range(2, 254)), 250, 16, -1);
        run_ticks(STEP_RESET, 100, 4, -1);

        // Wait for the last owed frames, then a few more cycles for strays.
        drain_frames();
        repeat (4) @(posedge clk);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
